@@ rtl/qpr_pkg.sv @@
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared widths, register indexes and types of the quaternion point rotator.
// ----------------------------------------------------------------------------
package qpr_pkg;

	localparam int COORD_WIDTH    = 32;
	localparam int QUAT_FRAC_BITS = 14;
	localparam int QUAT_WIDTH     = 16;
	localparam int DATA_WIDTH     = 32;
	localparam int ADDR_WIDTH     = 4;

	// first product: coordinate times quaternion component, three-term sum
	localparam int P1_WIDTH     = COORD_WIDTH + QUAT_WIDTH;
	localparam int S1_WIDTH_MIN = P1_WIDTH + 2;
	localparam int S1_WIDTH     = (S1_WIDTH_MIN > QUAT_FRAC_BITS + 2) ?
		S1_WIDTH_MIN : QUAT_FRAC_BITS + 2;
	localparam int T_WIDTH      = S1_WIDTH - QUAT_FRAC_BITS;

	// second product: intermediate term times component, four-term sum
	localparam int P2_WIDTH     = T_WIDTH + QUAT_WIDTH;
	localparam int S2_WIDTH_MIN = P2_WIDTH + 3;
	localparam int S2_WIDTH     = (S2_WIDTH_MIN > COORD_WIDTH + QUAT_FRAC_BITS) ?
		S2_WIDTH_MIN : COORD_WIDTH + QUAT_FRAC_BITS + 1;
	localparam int F_WIDTH      = S2_WIDTH - QUAT_FRAC_BITS;

	localparam logic [1:0] REG_SCALAR = 2'd0;
	localparam logic [1:0] REG_I      = 2'd1;
	localparam logic [1:0] REG_J      = 2'd2;
	localparam logic [1:0] REG_K      = 2'd3;

	localparam logic signed [QUAT_WIDTH-1:0] SCALAR_RESET =
		QUAT_WIDTH'(1 << QUAT_FRAC_BITS);

	typedef struct packed {
		logic signed [QUAT_WIDTH-1:0] s;
		logic signed [QUAT_WIDTH-1:0] i;
		logic signed [QUAT_WIDTH-1:0] j;
		logic signed [QUAT_WIDTH-1:0] k;
	} quat_t;

endpackage

@@ rtl/qpr_regs.sv @@
// ----------------------------------------------------------------------------
// qpr_regs
// APB register file holding the rotation quaternion.
// ----------------------------------------------------------------------------
module qpr_regs import qpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [DATA_WIDTH-1:0] pwdata,
	output logic [DATA_WIDTH-1:0] prdata,
	output quat_t                 quat
);

	quat_t quat_q;
	logic  wr_en;
	logic  [QUAT_WIDTH-1:0] rd_val;

	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.s <= SCALAR_RESET;
			quat_q.i <= '0;
			quat_q.j <= '0;
			quat_q.k <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_SCALAR: quat_q.s <= pwdata[QUAT_WIDTH-1:0];
				REG_I:      quat_q.i <= pwdata[QUAT_WIDTH-1:0];
				REG_J:      quat_q.j <= pwdata[QUAT_WIDTH-1:0];
				REG_K:      quat_q.k <= pwdata[QUAT_WIDTH-1:0];
				default:    quat_q.s <= quat_q.s;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SCALAR: rd_val = quat_q.s;
			REG_I:      rd_val = quat_q.i;
			REG_J:      rd_val = quat_q.j;
			REG_K:      rd_val = quat_q.k;
			default:    rd_val = '0;
		endcase
	end

	// misaligned reads return zero
	assign prdata = (paddr[1:0] == 2'b00) ?
		{{(DATA_WIDTH-QUAT_WIDTH){1'b0}}, rd_val} : '0;
	assign quat = quat_q;

endmodule

@@ rtl/quaternion_point_rotate.sv @@
// ----------------------------------------------------------------------------
// quaternion_point_rotate
// Rotates 3D points by a preloaded quaternion, six-stage pipeline.
// ----------------------------------------------------------------------------
// A new point may be started in every cycle, so the block sustains one
// point per clock; busy stays low. The pipeline stages are the input
// register, first multiply bank, first rounded sum, second multiply bank,
// second rounded sum, saturation and output register. Results appear for
// one cycle with done high and are not held; the receiver must take them
// then. The quaternion registers are read live and may only change while
// no point is in flight.
module quaternion_point_rotate import qpr_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] x_in,
	input  logic signed [COORD_WIDTH-1:0] y_in,
	input  logic signed [COORD_WIDTH-1:0] z_in,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] x_out,
	output logic signed [COORD_WIDTH-1:0] y_out,
	output logic signed [COORD_WIDTH-1:0] z_out,
	output logic                          clipped,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_WIDTH-1:0]         paddr,
	input  logic [DATA_WIDTH-1:0]         pwdata,
	output logic [DATA_WIDTH-1:0]         prdata,
	output logic                          pready
);

	localparam logic [S1_WIDTH-1:0] RND1 = S1_WIDTH'(1) << (QUAT_FRAC_BITS - 1);
	localparam logic [S2_WIDTH-1:0] RND2 = S2_WIDTH'(1) << (QUAT_FRAC_BITS - 1);

	quat_t quat;
	logic signed [QUAT_WIDTH-1:0] qc [4];

	logic [6:1] v_s;

	logic signed [COORD_WIDTH-1:0] pt_s1   [3];
	logic signed [P1_WIDTH-1:0]    prod_s2 [3][4];
	logic signed [S1_WIDTH-1:0]    sum1    [4];
	logic signed [T_WIDTH-1:0]     t_s3    [4];
	logic signed [P2_WIDTH-1:0]    prod_s4 [4][4];
	logic signed [S2_WIDTH-1:0]    sum2    [3];
	logic signed [F_WIDTH-1:0]     r_s5    [3];
	logic [COORD_WIDTH:0]          sat     [3];
	logic signed [COORD_WIDTH-1:0] o_s6    [3];
	logic                          clip_s6;

	qpr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.quat    (quat)
	);

	assign pready = 1'b1;
	assign busy   = 1'b0;

	// component order: scalar, i, j, k
	assign qc[0] = quat.s;
	assign qc[1] = quat.i;
	assign qc[2] = quat.j;
	assign qc[3] = quat.k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[5:1], start & ~busy};
		end
	end

	// returns {clip, value}
	function automatic logic [COORD_WIDTH:0] saturate(input logic [F_WIDTH-1:0] v);
		logic [F_WIDTH-COORD_WIDTH:0] upper;
		upper = v[F_WIDTH-1:COORD_WIDTH-1];
		if ((&upper) || !(|upper)) begin
			saturate = {1'b0, v[COORD_WIDTH-1:0]};
		end else begin
			saturate = {1'b1, v[F_WIDTH-1], {(COORD_WIDTH-1){~v[F_WIDTH-1]}}};
		end
	endfunction

	// t = q * (0, p), products indexed [coordinate][component]
	always_comb begin
		sum1[0] = -S1_WIDTH'(prod_s2[0][1]) - S1_WIDTH'(prod_s2[1][2])
			- S1_WIDTH'(prod_s2[2][3]) + RND1;
		sum1[1] =  S1_WIDTH'(prod_s2[0][0]) - S1_WIDTH'(prod_s2[1][3])
			+ S1_WIDTH'(prod_s2[2][2]) + RND1;
		sum1[2] =  S1_WIDTH'(prod_s2[0][3]) + S1_WIDTH'(prod_s2[1][0])
			- S1_WIDTH'(prod_s2[2][1]) + RND1;
		sum1[3] = -S1_WIDTH'(prod_s2[0][2]) + S1_WIDTH'(prod_s2[1][1])
			+ S1_WIDTH'(prod_s2[2][0]) + RND1;
	end

	// vector part of t * conj(q), products indexed [t term][component]
	always_comb begin
		sum2[0] = -S2_WIDTH'(prod_s4[0][1]) + S2_WIDTH'(prod_s4[1][0])
			- S2_WIDTH'(prod_s4[2][3]) + S2_WIDTH'(prod_s4[3][2]) + RND2;
		sum2[1] = -S2_WIDTH'(prod_s4[0][2]) + S2_WIDTH'(prod_s4[1][3])
			+ S2_WIDTH'(prod_s4[2][0]) - S2_WIDTH'(prod_s4[3][1]) + RND2;
		sum2[2] = -S2_WIDTH'(prod_s4[0][3]) - S2_WIDTH'(prod_s4[1][2])
			+ S2_WIDTH'(prod_s4[2][1]) + S2_WIDTH'(prod_s4[3][0]) + RND2;
	end

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			sat[n] = saturate(r_s5[n]);
		end
	end

	always_ff @(posedge clk) begin
		pt_s1[0] <= x_in;
		pt_s1[1] <= y_in;
		pt_s1[2] <= z_in;
		for (int c = 0; c < 3; c++) begin
			for (int m = 0; m < 4; m++) begin
				prod_s2[c][m] <= pt_s1[c] * qc[m];
			end
		end
		for (int n = 0; n < 4; n++) begin
			t_s3[n] <= sum1[n][S1_WIDTH-1:QUAT_FRAC_BITS];
		end
		for (int n = 0; n < 4; n++) begin
			for (int m = 0; m < 4; m++) begin
				prod_s4[n][m] <= t_s3[n] * qc[m];
			end
		end
		for (int n = 0; n < 3; n++) begin
			r_s5[n] <= sum2[n][S2_WIDTH-1:QUAT_FRAC_BITS];
		end
		for (int n = 0; n < 3; n++) begin
			o_s6[n] <= sat[n][COORD_WIDTH-1:0];
		end
		clip_s6 <= sat[0][COORD_WIDTH] | sat[1][COORD_WIDTH] | sat[2][COORD_WIDTH];
	end

	assign done    = v_s[6];
	assign x_out   = o_s6[0];
	assign y_out   = o_s6[1];
	assign z_out   = o_s6[2];
	assign clipped = v_s[6] & clip_s6;

endmodule

@@ rtl/qpr_checker.sv @@
// ----------------------------------------------------------------------------
// qpr_checker
// Port-level checks of the quaternion point rotator, bound to the top level.
// ----------------------------------------------------------------------------
module qpr_checker import qpr_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic signed [COORD_WIDTH-1:0] x_out,
	input logic signed [COORD_WIDTH-1:0] y_out,
	input logic signed [COORD_WIDTH-1:0] z_out,
	input logic                          clipped
);

	localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// every accepted transaction yields exactly one result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("result missing six cycles after start");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##6 !done)
		else $error("result without a matching start");

	a_clip_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		clipped |-> done)
		else $error("clipped raised outside a result");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |-> (x_out == CMAX || x_out == CMIN || y_out == CMAX ||
			y_out == CMIN || z_out == CMAX || z_out == CMIN))
		else $error("clipped set but no coordinate at a limit");

endmodule

bind quaternion_point_rotate qpr_checker u_qpr_checker (.*);

@@ verif/tb_quaternion_point_rotate.sv @@
// ----------------------------------------------------------------------------
// tb_quaternion_point_rotate
// Self-checking testbench for the quaternion point rotator. Points are sent
// through the start/busy command port and every done result is compared with
// an in-bench fixed-point predictor. The rotation quaternion is loaded over
// APB between bursts, while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_quaternion_point_rotate;
	import qpr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CLK_HALF     = 4;
	localparam int  DRAIN_CYCLES = 12;
	localparam int  MAX_GAP      = 40;
	localparam int  CYCLE_LIMIT  = 400000;
	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef struct {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
		logic                          clip;
	} point_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic signed [COORD_WIDTH-1:0] x_in;
	logic signed [COORD_WIDTH-1:0] y_in;
	logic signed [COORD_WIDTH-1:0] z_in;
	logic                          done;
	logic signed [COORD_WIDTH-1:0] x_out;
	logic signed [COORD_WIDTH-1:0] y_out;
	logic signed [COORD_WIDTH-1:0] z_out;
	logic                          clipped;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ADDR_WIDTH-1:0]         paddr;
	logic [DATA_WIDTH-1:0]         pwdata;
	logic [DATA_WIDTH-1:0]         prdata;
	logic                          pready;

	quat_t  rot_q;
	point_t rotated_q[$];
	int     idle_pct;
	int     error_count;
	int     cycle_count;

	quaternion_point_rotate i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.x_in    (x_in),
		.y_in    (y_in),
		.z_in    (z_in),
		.done    (done),
		.x_out   (x_out),
		.y_out   (y_out),
		.z_out   (z_out),
		.clipped (clipped),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// rounded product stage: add half an lsb, then floor
	function automatic longint round_stage(input longint acc);
		return (acc + (longint'(1) << (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] saturate(input longint v,
		inout logic clip);
		longint hi;
		longint lo;
		hi = longint'(COORD_MAX);
		lo = longint'(COORD_MIN);
		if (v > hi) begin
			clip = 1'b1;
			return COORD_MAX;
		end
		if (v < lo) begin
			clip = 1'b1;
			return COORD_MIN;
		end
		return COORD_WIDTH'(v);
	endfunction

	function automatic point_t rotate_point(input quat_t q,
		input logic signed [COORD_WIDTH-1:0] px, py, pz);
		longint s, qi, qj, qk, x, y, z;
		longint t0, t1, t2, t3;
		point_t r;
		s  = longint'($signed(q.s));
		qi = longint'($signed(q.i));
		qj = longint'($signed(q.j));
		qk = longint'($signed(q.k));
		x  = longint'(px);
		y  = longint'(py);
		z  = longint'(pz);
		// q times the pure point
		t0 = round_stage(-qi * x - qj * y - qk * z);
		t1 = round_stage(s * x - qk * y + qj * z);
		t2 = round_stage(qk * x + s * y - qi * z);
		t3 = round_stage(-qj * x + qi * y + s * z);
		// vector part of t times conj(q)
		r.clip = 1'b0;
		r.x = saturate(round_stage(-qi * t0 + s * t1 - qk * t2 + qj * t3), r.clip);
		r.y = saturate(round_stage(-qj * t0 + qk * t1 + s * t2 - qi * t3), r.clip);
		r.z = saturate(round_stage(-qk * t0 - qj * t1 + qi * t2 + s * t3), r.clip);
		return r;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
		case ($urandom_range(5))
			0, 1, 2: return COORD_WIDTH'($urandom);
			3:       return COORD_WIDTH'(int'($urandom_range(2000)) - 1000);
			4:       return ($urandom_range(1) != 0) ? COORD_MAX : COORD_MIN;
			default: return COORD_WIDTH'($signed($urandom) >>> $urandom_range(31));
		endcase
	endfunction

	task automatic end_burst();
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_point(input logic signed [COORD_WIDTH-1:0] x, y, z);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct && gap < MAX_GAP)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		x_in  <= x;
		y_in  <= y;
		z_in  <= z;
		do @(posedge clk); while (busy);
		rotated_q.push_back(rotate_point(rot_q, x, y, z));
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic signed [QUAT_WIDTH-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_WIDTH'({idx, 2'b00});
		pwdata  <= DATA_WIDTH'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_SCALAR: rot_q.s = v;
			REG_I:      rot_q.i = v;
			REG_J:      rot_q.j = v;
			REG_K:      rot_q.k = v;
		endcase
		@(posedge clk);
	endtask

	// only reprogram once the pipeline has emptied
	task automatic set_rotation(input logic signed [QUAT_WIDTH-1:0] s, i, j, k);
		end_burst();
		while (rotated_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		apb_write(REG_SCALAR, s);
		apb_write(REG_I, i);
		apb_write(REG_J, j);
		apb_write(REG_K, k);
	endtask

	task automatic test_identity();
		send_point(0, 0, 0);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN);
		send_point(COORD_MAX, COORD_MIN, 1);
		send_point(-1, 0, -1);
		send_point(COORD_MIN, COORD_MAX, 0);
	endtask

	task automatic test_extreme_rotations();
		logic signed [QUAT_WIDTH-1:0] cfg[4][4];
		cfg = '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
			'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
			'{16'sd0, 16'sd16384, 16'sd0, 16'sd0},
			'{16'sd11585, 16'sd0, 16'sd0, 16'sd11585}};
		foreach (cfg[n]) begin
			set_rotation(cfg[n][0], cfg[n][1], cfg[n][2], cfg[n][3]);
			send_point(COORD_MIN, COORD_MAX, 12345);
			send_point(1000, -2000, 3000);
			send_point(COORD_MAX, COORD_MAX, COORD_MIN);
		end
	endtask

	// scalar of one half puts odd coordinates exactly on a rounding tie
	task automatic test_half_rounding();
		set_rotation(16'sd8192, 16'sd0, 16'sd0, 16'sd0);
		send_point(1, 3, -1);
		send_point(-3, 5, 7);
		send_point(COORD_MAX, COORD_MIN, -1);
	endtask

	task automatic test_random_rotations(input int pct, input int settings, input int points);
		real a, b, c, d, norm;
		logic signed [QUAT_WIDTH-1:0] qs, qi, qj, qk;
		for (int n = 0; n < settings; n++) begin
			if ($urandom_range(3) == 0) begin
				qs = QUAT_WIDTH'($urandom);
				qi = QUAT_WIDTH'($urandom);
				qj = QUAT_WIDTH'($urandom);
				qk = QUAT_WIDTH'($urandom);
			end else begin
				// near-unit quaternion, the normal use
				a = real'(int'($urandom_range(2000)) - 1000);
				b = real'(int'($urandom_range(2000)) - 1000);
				c = real'(int'($urandom_range(2000)) - 1000);
				d = real'(int'($urandom_range(2000)) - 1000);
				norm = $sqrt(a * a + b * b + c * c + d * d);
				if (norm == 0.0) begin
					a = 1.0;
					norm = 1.0;
				end
				qs = QUAT_WIDTH'($rtoi(a / norm * 16384.0));
				qi = QUAT_WIDTH'($rtoi(b / norm * 16384.0));
				qj = QUAT_WIDTH'($rtoi(c / norm * 16384.0));
				qk = QUAT_WIDTH'($rtoi(d / norm * 16384.0));
			end
			set_rotation(qs, qi, qj, qk);
			idle_pct = pct;
			for (int p = 0; p < points; p++)
				send_point(rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	always @(posedge clk) begin
		point_t want;
		if (arst_n && done) begin
			if (rotated_q.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d z=%0d clipped=%0b",
					$time, x_out, y_out, z_out, clipped);
				error_count++;
			end else begin
				want = rotated_q.pop_front();
				if (x_out !== want.x) begin
					$display("%0t: x_out expected %0d actual %0d", $time, want.x, x_out);
					error_count++;
				end
				if (y_out !== want.y) begin
					$display("%0t: y_out expected %0d actual %0d", $time, want.y, y_out);
					error_count++;
				end
				if (z_out !== want.z) begin
					$display("%0t: z_out expected %0d actual %0d", $time, want.z, z_out);
					error_count++;
				end
				if (clipped !== want.clip) begin
					$display("%0t: clipped expected %0b actual %0b", $time, want.clip,
						clipped);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("quaternion_point_rotate: mismatch");
			$finish;
		end
	end

	initial begin
		int wait_cycles;
		error_count = 0;
		cycle_count = 0;
		idle_pct    = 0;
		rot_q.s     = SCALAR_RESET;
		rot_q.i     = '0;
		rot_q.j     = '0;
		rot_q.k     = '0;
		arst_n  <= 1'b0;
		start   <= 1'b0;
		x_in    <= '0;
		y_in    <= '0;
		z_in    <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 32;
		test_identity();
		test_extreme_rotations();
		test_half_rounding();
		test_random_rotations(32, 8, 50);
		test_random_rotations(75, 8, 50);
		test_random_rotations(0, 8, 50);
		end_burst();

		wait_cycles = 0;
		while (rotated_q.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && rotated_q.size() == 0) begin
			$display("quaternion_point_rotate: match");
		end else begin
			if (rotated_q.size() != 0)
				$display("%0t: %0d results never arrived", $time, rotated_q.size());
			$display("quaternion_point_rotate: mismatch");
		end
		$finish;
	end

endmodule

@@ quaternion_point_rotate.f @@
rtl/qpr_pkg.sv
rtl/qpr_regs.sv
rtl/quaternion_point_rotate.sv
rtl/qpr_checker.sv
verif/tb_quaternion_point_rotate.sv
